// ===== rtl/cffs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cffs_pkg
// Shared types and constants for the circular first-free slot allocator.
// ----------------------------------------------------------------------------
package cffs_pkg;

   // fixed field widths
   localparam int SLOT_W  = 6;
   localparam int COUNT_W = 7;

   // slot count after reset
   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

   // request operation codes
   typedef enum logic [0:0] {
      OP_ALLOC   = 1'b0,
      OP_RELEASE = 1'b1
   } slot_op_type;

   // request handed to the slot map in the cycle it is processed
   typedef struct packed {
      logic              valid;
      slot_op_type       op;
      logic [SLOT_W-1:0] index;
   } map_cmd_type;

   // allocate outcome from the slot map
   typedef struct packed {
      logic [SLOT_W-1:0] granted_slot;
      logic              none_free;
   } map_rsp_type;

endpackage

// ===== rtl/cffs_find.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cffs_find
// Priority encoder: position of the lowest set bit of a mask.
// ----------------------------------------------------------------------------
module cffs_find #(
   parameter int W  = 64,
   parameter int IW = (W > 1) ? $clog2(W) : 1
) (
   input  logic [W-1:0]  req_mask,
   output logic          found,
   output logic [IW-1:0] pos
);

   // scan from the top so the lowest set bit wins
   always_comb begin
      found = |req_mask;
      pos   = '0;
      for (int i = W - 1; i >= 0; i--) begin
         if (req_mask[i]) begin
            pos = IW'(i);
         end
      end
   end

endmodule

// ===== rtl/cffs_slot_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cffs_slot_map
// Occupancy bitmap, slot count register and the circular first-free search.
// ----------------------------------------------------------------------------
module cffs_slot_map import cffs_pkg::*; #(
   parameter int MAX_SLOTS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data,
   input  map_cmd_type        cmd,
   output map_rsp_type        rsp
);

   localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_SLOTS);

   logic [COUNT_W-1:0]   slot_count_ff;
   logic [MAX_SLOTS-1:0] map_ff;
   logic [MAX_SLOTS-1:0] map_in;

   logic [COUNT_W-1:0]   eff_count;
   logic                 in_range;
   logic [COUNT_W-1:0]   start;
   logic [MAX_SLOTS-1:0] live_mask;
   logic [MAX_SLOTS-1:0] upper_mask;
   logic [MAX_SLOTS-1:0] free_mask;
   logic [MAX_SLOTS-1:0] high_mask;
   logic [MAX_SLOTS-1:0] pick_mask;
   logic                 found;
   logic [IW-1:0]        pick_pos;

   // slot count register
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= COUNT_RESET;
      end else if (csr_wr_en) begin
         slot_count_ff <= csr_wr_data;
      end
   end

   // clamp count, pick the search start
   assign eff_count = (slot_count_ff > MaxCount) ? MaxCount : slot_count_ff;
   assign in_range  = ({1'b0, cmd.index} < eff_count);
   assign start     = in_range ? {1'b0, cmd.index} : '0;

   // live slots and slots at or after the start
   always_comb begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
         live_mask[i]  = (COUNT_W'(i) < eff_count);
         upper_mask[i] = (COUNT_W'(i) >= start);
      end
   end

   // search upper part first, wrap to the whole range
   assign free_mask = ~map_ff & live_mask;
   assign high_mask = free_mask & upper_mask;
   assign pick_mask = (|high_mask) ? high_mask : free_mask;

   cffs_find #(
      .W  (MAX_SLOTS),
      .IW (IW)
   ) u_find (
      .req_mask (pick_mask),
      .found    (found),
      .pos      (pick_pos)
   );

   // allocate outcome
   assign rsp.granted_slot = found ? SLOT_W'(pick_pos) : '0;
   assign rsp.none_free    = ~found;

   // bitmap update
   always_comb begin
      map_in = map_ff;
      if (cmd.valid) begin
         unique case (cmd.op)
            OP_ALLOC: begin
               if (found) begin
                  map_in = map_ff | (MAX_SLOTS'(1) << pick_pos);
               end
            end
            OP_RELEASE: begin
               if (in_range) begin
                  map_in = map_ff & ~(MAX_SLOTS'(1) << cmd.index);
               end
            end
            default: begin
               map_in = map_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= '0;
      end else begin
         map_ff <= map_in;
      end
   end

endmodule

// ===== rtl/circular_first_free_slot_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_first_free_slot_allocator
// Grants the first free slot at or after a preferred slot, wrapping around.
// ----------------------------------------------------------------------------
// Usage:
// - request channel (req_valid / req_stall): req_type selects allocate or
//   release, req_slot_index is the preferred slot or the slot to free.
// - response channel (rsp_valid / rsp_stall): one response per allocate,
//   carrying rsp_granted_slot and rsp_none_free; a release gives none.
// - csr_wr_en / csr_wr_data set the number of slots in use; write it only
//   while no request is in flight.
// Timing: a request waits in the input register until it can leave; the
// bitmap search and update happen in the cycle it leaves. The response
// is registered: an allocate passes the input register and then the
// response register. One request is accepted every cycle while req_stall
// is low; the bitmap read, priority encode and write share a cycle, so
// back-to-back allocates see each other.
// Reset: all slots free, slot count 64, both stages empty.
// Stall: a held response blocks an allocate in the input register, which
// then stalls the request channel; releases still drain.
// ----------------------------------------------------------------------------
module circular_first_free_slot_allocator import cffs_pkg::*; #(
   parameter int MAX_SLOTS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic [SLOT_W-1:0]  req_slot_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [SLOT_W-1:0]  rsp_granted_slot,
   output logic               rsp_none_free,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data
);

   logic              s1_valid_ff;
   logic              s1_valid_in;
   slot_op_type       s1_op_ff;
   logic [SLOT_W-1:0] s1_idx_ff;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   map_rsp_type       rsp_ff;

   logic              out_free;
   logic              s1_go;
   logic              s1_alloc_go;
   logic              req_fire;
   map_cmd_type       cmd;
   map_rsp_type       map_rsp;

   // handshake
   assign out_free    = ~rsp_valid_ff | ~rsp_stall;
   assign s1_go       = s1_valid_ff & ((s1_op_ff == OP_RELEASE) | out_free);
   assign s1_alloc_go = s1_go & (s1_op_ff == OP_ALLOC);
   assign req_stall   = s1_valid_ff & ~s1_go;
   assign req_fire    = req_valid & ~req_stall;

   // input register
   assign s1_valid_in = req_fire | (s1_valid_ff & ~s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff  <= slot_op_type'(req_type);
         s1_idx_ff <= req_slot_index;
      end
   end

   // slot map
   assign cmd.valid = s1_go;
   assign cmd.op    = s1_op_ff;
   assign cmd.index = s1_idx_ff;

   cffs_slot_map #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_slot_map (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .rsp         (map_rsp)
   );

   // response register
   always_comb begin
      if (s1_alloc_go) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_alloc_go) begin
         rsp_ff <= map_rsp;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_slot = rsp_ff.granted_slot;
   assign rsp_none_free    = rsp_ff.none_free;

`ifndef SYNTHESIS
   // the request side only stalls behind an allocate blocked by the output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_op_ff == OP_ALLOC && rsp_valid_ff && rsp_stall))
      else $error("request stall without a blocked allocate");

   // every allocate that leaves the input register shows a response next
   a_alloc_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_alloc_go |=> rsp_valid_ff)
      else $error("allocate produced no response");

   // a taken response with nothing behind it empties the output register
   a_rsp_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !s1_alloc_go) |=> !rsp_valid_ff)
      else $error("response repeated after it was taken");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the circular first-free slot allocator. Requests go
// out with random gaps, responses are taken under random stall, and every
// accepted request updates a local copy of the slot bitmap that predicts
// each grant. Directed cases come first, then a map fill and phases of random
// allocate / release traffic under several slot counts.
// ----------------------------------------------------------------------------
module tb_top;
   import cffs_pkg::*;

   localparam int SLOT_TOTAL   = 64;
   localparam int MAX_GAP      = 11;
   localparam int DRAIN_CYCLES = 4;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 90;
   localparam int PRINT_LIMIT  = 50;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_stall;
   logic               req_type       = OP_ALLOC;
   logic [SLOT_W-1:0]  req_slot_index = '0;
   logic               rsp_valid;
   logic               rsp_stall      = 1'b0;
   logic [SLOT_W-1:0]  rsp_granted_slot;
   logic               rsp_none_free;
   logic               csr_wr_en      = 1'b0;
   logic [COUNT_W-1:0] csr_wr_data    = '0;

   // local copy of the allocator state
   logic [SLOT_TOTAL-1:0] slot_map_model   = '0;
   logic [COUNT_W-1:0]    slot_count_model = COUNT_RESET;
   map_rsp_type           pending_grants[$];

   int error_count     = 0;
   int cycle_count     = 0;
   int rsp_hold_cycles = 0;
   bit idle_on         = 1'b1;

   circular_first_free_slot_allocator #(
      .MAX_SLOTS(SLOT_TOTAL)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_slot_index   (req_slot_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_none_free    (rsp_none_free),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   // clock, 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // slot count as the allocator sees it, clamped to the slot total
   function automatic int active_slots();
      return (slot_count_model > SLOT_TOTAL) ? SLOT_TOTAL : int'(slot_count_model);
   endfunction

   // update the bitmap copy for one accepted request, queue the grant it causes
   function automatic void predict_grant(slot_op_type op, logic [SLOT_W-1:0] idx);
      int          cnt;
      int          start;
      int          s;
      map_rsp_type grant;
      cnt = active_slots();
      if (op == OP_RELEASE) begin
         if (idx < cnt) slot_map_model[idx] = 1'b0;
         return;
      end
      start = (idx < cnt) ? int'(idx) : 0;
      for (int k = 0; k < cnt; k++) begin
         s = start + k;
         if (s >= cnt) s -= cnt;
         if (!slot_map_model[s]) begin
            slot_map_model[s]  = 1'b1;
            grant.granted_slot = s[SLOT_W-1:0];
            grant.none_free    = 1'b0;
            pending_grants.push_back(grant);
            return;
         end
      end
      grant.granted_slot = '0;
      grant.none_free    = 1'b1;
      pending_grants.push_back(grant);
   endfunction

   // a taken slot inside the active range if one exists, else any slot
   function automatic logic [SLOT_W-1:0] pick_busy_slot();
      int start;
      int s;
      start = $urandom_range(0, SLOT_TOTAL - 1);
      for (int k = 0; k < SLOT_TOTAL; k++) begin
         s = (start + k) % SLOT_TOTAL;
         if (s < active_slots() && slot_map_model[s]) return s[SLOT_W-1:0];
      end
      return start[SLOT_W-1:0];
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   // one request, called and returning at a falling edge
   task automatic send_request(input slot_op_type op, input logic [SLOT_W-1:0] idx);
      int gap;
      gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= op;
      req_slot_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_grant(op, idx);
      @(negedge clock);
   endtask

   // stop sending and wait until every grant is back and releases have settled
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_slot_count(input logic [COUNT_W-1:0] value);
      drain_pipeline();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en        <= 1'b0;
      slot_count_model = value;
   endtask

   // response check against the oldest queued grant
   always @(posedge clock) begin
      map_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_grants.size() == 0) begin
            report_mismatch("unexpected response, slot", rsp_granted_slot, 0);
         end else begin
            want = pending_grants.pop_front();
            if (rsp_granted_slot !== want.granted_slot)
               report_mismatch("granted_slot", rsp_granted_slot, want.granted_slot);
            if (rsp_none_free !== want.none_free)
               report_mismatch("none_free", rsp_none_free, want.none_free);
         end
         rsp_hold_cycles = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      end
   end

   // response side stall
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_cycles--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // wraparound, out-of-range indexes, count extremes, kept bits above the count
   task automatic test_directed_cases();
      send_request(OP_ALLOC, 6'd0);
      send_request(OP_ALLOC, 6'd63);
      send_request(OP_ALLOC, 6'd63);
      send_request(OP_RELEASE, 6'd63);
      send_request(OP_RELEASE, 6'd63);
      send_request(OP_ALLOC, 6'd63);
      write_slot_count(7'd4);
      send_request(OP_ALLOC, 6'd2);
      send_request(OP_ALLOC, 6'd2);
      send_request(OP_ALLOC, 6'd2);
      send_request(OP_ALLOC, 6'd40);
      send_request(OP_RELEASE, 6'd63);
      send_request(OP_RELEASE, 6'd3);
      send_request(OP_ALLOC, 6'd40);
      write_slot_count(7'd64);
      send_request(OP_ALLOC, 6'd4);
      send_request(OP_ALLOC, 6'd63);
      write_slot_count(7'd0);
      send_request(OP_ALLOC, 6'd0);
      send_request(OP_RELEASE, 6'd0);
      write_slot_count(7'd127);
      send_request(OP_ALLOC, 6'd62);
      write_slot_count(7'd1);
      send_request(OP_ALLOC, 6'd0);
      send_request(OP_RELEASE, 6'd0);
      send_request(OP_ALLOC, 6'd9);
   endtask

   // fill every slot, allocate into a full map, then free everything
   task automatic test_full_map();
      write_slot_count(7'd64);
      while (slot_map_model != '1)
         send_request(OP_ALLOC, SLOT_W'($urandom_range(0, SLOT_TOTAL - 1)));
      send_request(OP_ALLOC, SLOT_W'($urandom_range(0, SLOT_TOTAL - 1)));
      send_request(OP_ALLOC, 6'd63);
      send_request(OP_RELEASE, 6'd17);
      send_request(OP_ALLOC, 6'd50);
      for (int s = 0; s < SLOT_TOTAL; s++)
         send_request(OP_RELEASE, s[SLOT_W-1:0]);
   endtask

   // mostly allocate / release churn on live slots, some noise
   task automatic test_random_traffic();
      logic [COUNT_W-1:0] counts[13];
      logic [SLOT_W-1:0]  idx;
      int                 r;
      counts = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd2, 7'd33, 7'd64, 7'd8, 7'd100, 7'd63,
                 7'd17, 7'd0, 7'd0};
      counts[11] = COUNT_W'($urandom_range(0, 127));
      counts[12] = COUNT_W'($urandom_range(0, 127));
      for (int p = 0; p < 13; p++) begin
         write_slot_count(counts[p]);
         idle_on = (p % 4) != 3;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // halfway through, the sender holds off until the pipeline is empty
            if (i == PHASE_ITEMS / 2) drain_pipeline();
            r = $urandom_range(0, 99);
            if (r < 50) begin
               if (active_slots() == 0 || $urandom_range(0, 3) == 0)
                  idx = SLOT_W'($urandom_range(0, SLOT_TOTAL - 1));
               else
                  idx = SLOT_W'($urandom_range(0, active_slots() - 1));
               send_request(OP_ALLOC, idx);
            end else if (r < 85) begin
               send_request(OP_RELEASE, pick_busy_slot());
            end else begin
               send_request($urandom_range(0, 1) ? OP_RELEASE : OP_ALLOC,
                            SLOT_W'($urandom_range(0, SLOT_TOTAL - 1)));
            end
         end
      end
      idle_on = 1'b1;
   endtask

   // test sequence
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_full_map();
      test_random_traffic();
      drain_pipeline();
      repeat (2 * DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/cffs_pkg.sv
rtl/cffs_find.sv
rtl/cffs_slot_map.sv
rtl/circular_first_free_slot_allocator.sv
test/tb_top.sv
